// ===== rtl/assert_macros.svh =====
// assertion helpers for the checker modules
// the enclosing module must provide clk and rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, quiet while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// concurrent check that also runs through reset
`define ASSERT_CLK_NR(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/clcd_pkg.sv =====
`default_nettype none
package clcd_pkg;

  // request opcodes, code seven is unused
  typedef enum logic [2:0] {
    OP_INIT       = 3'd0,
    OP_CLEAR      = 3'd1,
    OP_SET_POS    = 3'd2,
    OP_CURSOR     = 3'd3,
    OP_RAW_CHAR   = 3'd4,
    OP_XLAT_CHAR  = 3'd5,
    OP_RAW_CMD    = 3'd6
  } clcd_op_t;

  // waits in microseconds
  localparam logic [15:0] POWERUP_WAIT_US = 16'd40000;
  localparam logic [15:0] WAIT_INIT_US    = 16'd1000;
  localparam logic [15:0] WAIT_LONG_US    = 16'd2000;
  localparam logic [15:0] WAIT_POS_US     = 16'd50;
  localparam logic [15:0] WAIT_CHAR_US    = 16'd100;
  localparam logic [15:0] WAIT_RAW_US     = 16'd0;

  // command bytes
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_DDRAM_ADDR = 8'h80;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;

  // init sequence: one powerup wait, then eight commands
  localparam logic [3:0] INIT_LAST_STEP = 4'd8;

  // windows-1251 special letters
  localparam logic [7:0] CP_YO_UPPER  = 8'hA8;
  localparam logic [7:0] CP_YO_LOWER  = 8'hB8;
  localparam logic [7:0] ROM_YO_UPPER = 8'hA2;
  localparam logic [7:0] ROM_YO_LOWER = 8'hB5;
  localparam logic [7:0] CP_CYR_FIRST = 8'hC0;

  localparam logic [7:0] CYR_ROM [64] = '{
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
    8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
    8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
    8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
    8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
    8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
    8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

  // one bus item as produced by the item generator
  typedef struct packed {
    logic        has_res;
    logic        strobe;
    logic        rs;
    logic [7:0]  bus_byte;
    logic [15:0] wait_us;
    logic        last;
  } clcd_item_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0, 3'd1, 3'd2: c = 8'h30;
      3'd3, 3'd4:       c = 8'h38;
      3'd5:             c = 8'h0F;
      3'd6:             c = 8'h01;
      3'd7:             c = 8'h06;
      default:          c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] init_wait(input logic [2:0] idx);
    return (idx >= 3'd6) ? WAIT_LONG_US : WAIT_INIT_US;
  endfunction

  function automatic logic [7:0] row_base(input logic [1:0] r);
    logic [7:0] b;
    unique case (r)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      2'd3:    b = 8'h54;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] translate(input logic [7:0] c);
    logic [7:0] t;
    priority if (c == CP_YO_UPPER) t = ROM_YO_UPPER;
    else if (c == CP_YO_LOWER)     t = ROM_YO_LOWER;
    else if (c >= CP_CYR_FIRST)    t = CYR_ROM[c[5:0]];
    else                           t = c;
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/clcd_item_gen.sv =====
`default_nettype none
module clcd_item_gen (
  input  logic [2:0]          op,
  input  logic [7:0]          value,
  input  logic [5:0]          column,
  input  logic [2:0]          row,
  input  logic [2:0]          style,
  input  logic [3:0]          step,
  output clcd_pkg::clcd_item_t item
);
  import clcd_pkg::*;

  logic [3:0] step_m1;
  logic [7:0] pos_addr;

  assign step_m1  = step - 4'd1;
  assign pos_addr = row_base(row[1:0]) + {2'b00, column};

  always_comb begin
    item = '0;
    item.last = 1'b1;
    unique case (clcd_op_t'(op))
      OP_INIT: begin
        item.has_res = 1'b1;
        item.last    = (step == INIT_LAST_STEP);
        if (step == 4'd0) begin
          // wait-only item, no strobe
          item.wait_us = POWERUP_WAIT_US;
        end else begin
          item.strobe   = 1'b1;
          item.bus_byte = init_cmd(step_m1[2:0]);
          item.wait_us  = init_wait(step_m1[2:0]);
        end
      end
      OP_CLEAR: begin
        item.has_res  = 1'b1;
        item.strobe   = 1'b1;
        item.bus_byte = CMD_CLEAR;
        item.wait_us  = WAIT_LONG_US;
      end
      OP_SET_POS: begin
        item.has_res  = ~row[2];
        item.strobe   = 1'b1;
        item.bus_byte = pos_addr | CMD_DDRAM_ADDR;
        item.wait_us  = WAIT_POS_US;
      end
      OP_CURSOR: begin
        item.has_res  = ~style[2];
        item.strobe   = 1'b1;
        item.bus_byte = CMD_DISPLAY_ON + {5'b00000, style};
        item.wait_us  = WAIT_LONG_US;
      end
      OP_RAW_CHAR: begin
        item.has_res  = 1'b1;
        item.strobe   = 1'b1;
        item.rs       = 1'b1;
        item.bus_byte = value;
        item.wait_us  = WAIT_CHAR_US;
      end
      OP_XLAT_CHAR: begin
        item.has_res  = 1'b1;
        item.strobe   = 1'b1;
        item.rs       = 1'b1;
        item.bus_byte = translate(value);
        item.wait_us  = WAIT_CHAR_US;
      end
      OP_RAW_CMD: begin
        item.has_res  = 1'b1;
        item.strobe   = 1'b1;
        item.bus_byte = value;
        item.wait_us  = WAIT_RAW_US;
      end
      default: begin
        item.has_res = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/char_lcd_command_sequencer.sv =====
`default_nettype none
// character-LCD command sequencer for an HD44780-style 8-bit bus. Each request
// item turns into zero or more bus items: a write (strobe_res high, register
// select, data byte) or a wait-only item, each carrying the microseconds to
// wait after it; last marks the final bus item of a request. The downstream
// pin-timing stage holds the enable pulse and the waits. Rate: a request that
// makes one bus item is taken every cycle while out_stall is low, passing
// through the request register into the output register; init makes nine
// bus items and stalls the input until its ninth bus item loads into the
// output register, its bus items counted by the step counter. A request
// that makes nothing (row above three, style above three, opcode seven)
// leaves without touching the output. The output register is the only
// place results wait.
module char_lcd_command_sequencer (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [7:0]  value,
  input  logic [5:0]  column,
  input  logic [2:0]  row,
  input  logic [2:0]  cursor_style,
  // bus item channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        strobe_res,
  output logic        register_select,
  output logic [7:0]  bus_byte,
  output logic [15:0] wait_after_us,
  output logic        last
);
  import clcd_pkg::*;

  // request register, held until its last bus item moves to the output
  logic       req_valid;
  logic [2:0] req_op;
  logic [7:0] req_value;
  logic [5:0] req_column;
  logic [2:0] req_row;
  logic [2:0] req_style;
  logic [3:0] step;

  clcd_item_t item;

  logic can_load;
  logic req_done;
  logic in_take;

  clcd_item_gen u_gen (
    .op     (req_op),
    .value  (req_value),
    .column (req_column),
    .row    (req_row),
    .style  (req_style),
    .step   (step),
    .item   (item)
  );

  // output register is free or emptying this cycle
  assign can_load = ~out_valid | ~out_stall;
  // request retires when it has nothing to send or its last item loads
  assign req_done = req_valid & (~item.has_res | (can_load & item.last));
  assign in_stall = req_valid & ~req_done;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      step      <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      // request side
      if (in_take) begin
        req_valid  <= 1'b1;
        req_op     <= opcode;
        req_value  <= value;
        req_column <= column;
        req_row    <= row;
        req_style  <= cursor_style;
        step       <= 4'd0;
      end else if (req_done) begin
        req_valid <= 1'b0;
        step      <= 4'd0;
      end else if (req_valid & item.has_res & can_load) begin
        step <= step + 4'd1;
      end

      // output side
      if (can_load) begin
        out_valid <= req_valid & item.has_res;
        if (req_valid & item.has_res) begin
          strobe_res      <= item.strobe;
          register_select <= item.rs;
          bus_byte        <= item.bus_byte;
          wait_after_us   <= item.wait_us;
          last            <= item.last;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/clcd_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module clcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        strobe_res,
  input logic        register_select,
  input logic [7:0]  bus_byte,
  input logic [15:0] wait_after_us,
  input logic        last
);
  import clcd_pkg::*;

  // stalled bus item stays put
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(bus_byte) && $stable(wait_after_us) && $stable(last), "stalled bus item changed")

  // wait-only item is the powerup wait with a quiet bus
  `ASSERT_CLK(a_wait_only, out_valid && !strobe_res |-> register_select == 1'b0 && bus_byte == 8'h00 && wait_after_us == POWERUP_WAIT_US, "bad wait-only item")

  // data writes always wait one character time
  `ASSERT_CLK(a_data_wait, out_valid && register_select |-> strobe_res && wait_after_us == WAIT_CHAR_US, "bad data write")

  // init in progress blocks new requests while output is stalled
  `ASSERT_CLK(a_init_blocks, out_valid && out_stall && !last |-> in_stall, "request taken mid init")

  // nothing leaves right after reset
  `ASSERT_CLK_NR(a_reset_empty, rst |=> !out_valid, "output valid after reset")

endmodule

bind char_lcd_command_sequencer clcd_checker u_clcd_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import clcd_pkg::*;

  // opcode seven has no member in the package enum, the block must ignore it
  localparam logic [2:0] OP_UNUSED_SEVEN = 3'd7;

  // idle odds out of a hundred, for both sides
  localparam int IDLE_PERCENT = 38;
  // receiver hold-off length while the sender keeps pushing
  localparam int HOLD_CYCLES = 120;
  // quiet cycles after the last expected bus item, covers the path of
  // requests that make nothing
  localparam int TAIL_CYCLES = 16;
  // worst case is far below this: ~130 requests, nine bus items each at most,
  // every one waiting out random stalls, plus the hold-off
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  // expected waits in microseconds
  localparam logic [15:0] POWERUP_US = 16'd40000;
  localparam logic [15:0] SETTLE_US = 16'd1000;
  localparam logic [15:0] SLOW_CMD_US = 16'd2000;
  localparam logic [15:0] ADDR_US = 16'd50;
  localparam logic [15:0] DATA_US = 16'd100;

  // power-up command bytes, the last two need the long wait
  localparam logic [0:7][7:0] POWERUP_BYTES = {
    8'h30, 8'h30, 8'h30, 8'h38, 8'h38, 8'h0F, 8'h01, 8'h06
  };

  // ddram base address of each line on a 20x4 module
  localparam logic [0:3][7:0] LINE_BASE = {8'h00, 8'h40, 8'h14, 8'h54};

  // lcd rom glyph for windows-1251 codes 0xc0..0xff
  localparam logic [0:63][7:0] CYRILLIC_GLYPH = {
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
    8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
    8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
    8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
    8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
    8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
    8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

  // one bus item as the pin-timing stage would see it
  typedef struct packed {
    logic        strobe;
    logic        rs;
    logic [7:0]  data;
    logic [15:0] wait_us;
    logic        last;
  } bus_item_t;

  logic clk = 1'b0;
  logic rst;

  // request side
  logic       in_valid;
  logic       in_stall;
  logic [2:0] opcode;
  logic [7:0] value;
  logic [5:0] column;
  logic [2:0] row;
  logic [2:0] cursor_style;

  // bus item side
  logic        out_valid;
  logic        out_stall;
  logic        strobe_res;
  logic        register_select;
  logic [7:0]  bus_byte;
  logic [15:0] wait_after_us;
  logic        bus_last;

  // bus items still owed by the block, oldest first
  bus_item_t expected_bus_items[$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  // no idling on either side while set
  bit  calm = 1'b0;
  // the receiver serves one long hold-off each time this count goes up
  int  holds_asked = 0;

  char_lcd_command_sequencer u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .value           (value),
    .column          (column),
    .row             (row),
    .cursor_style    (cursor_style),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .strobe_res      (strobe_res),
    .register_select (register_select),
    .bus_byte        (bus_byte),
    .wait_after_us   (wait_after_us),
    .last            (bus_last)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor: bus items a request turns into
  // ---------------------------------------------------------------------------

  function automatic void add_bus_item(input logic strobe, input logic rs,
                                       input logic [7:0] data,
                                       input logic [15:0] wait_us,
                                       input logic is_last);
    bus_item_t item;
    item.strobe = strobe;
    item.rs = rs;
    item.data = data;
    item.wait_us = wait_us;
    item.last = is_last;
    expected_bus_items.push_back(item);
  endfunction

  function automatic void predict_bus_items(input logic [2:0] op, input logic [7:0] v,
                                            input logic [5:0] col, input logic [2:0] r,
                                            input logic [2:0] style);
    logic [7:0] addr;
    logic [7:0] glyph;
    case (op)
      OP_INIT: begin
        // power-up wait carries no strobe and a zero bus
        add_bus_item(1'b0, 1'b0, 8'h00, POWERUP_US, 1'b0);
        for (int i = 0; i < 8; i++) begin
          add_bus_item(1'b1, 1'b0, POWERUP_BYTES[i], (i >= 6) ? SLOW_CMD_US : SETTLE_US,
                       i == 7);
        end
      end
      OP_CLEAR: add_bus_item(1'b1, 1'b0, 8'h01, SLOW_CMD_US, 1'b1);
      OP_SET_POS: begin
        // rows four to seven are dropped; the sum wraps in 8 bits, then bit 7 set
        if (r < 3'd4) begin
          addr = LINE_BASE[r[1:0]] + {2'b00, col};
          addr[7] = 1'b1;
          add_bus_item(1'b1, 1'b0, addr, ADDR_US, 1'b1);
        end
      end
      OP_CURSOR: begin
        if (style < 3'd4) begin
          add_bus_item(1'b1, 1'b0, 8'h0C + {5'd0, style}, SLOW_CMD_US, 1'b1);
        end
      end
      OP_RAW_CHAR: add_bus_item(1'b1, 1'b1, v, DATA_US, 1'b1);
      OP_XLAT_CHAR: begin
        // the two yo letters sit outside the contiguous cyrillic block
        if (v == 8'hA8) glyph = 8'hA2;
        else if (v == 8'hB8) glyph = 8'hB5;
        else if (v >= 8'hC0) glyph = CYRILLIC_GLYPH[v[5:0]];
        else glyph = v;
        add_bus_item(1'b1, 1'b1, glyph, DATA_US, 1'b1);
      end
      OP_RAW_CMD: add_bus_item(1'b1, 1'b0, v, 16'd0, 1'b1);
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------

  // offers one request and returns at the edge that takes it; valid is left
  // high so back-to-back requests need no second write in one step
  task automatic send_request(input logic [2:0] op, input logic [7:0] v,
                              input logic [5:0] col, input logic [2:0] r,
                              input logic [2:0] style);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    value <= v;
    column <= col;
    row <= r;
    cursor_style <= style;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_bus_items(op, v, col, r, style);
  endtask

  // mostly well-formed requests, with some out-of-range rows, styles and the
  // unused opcode mixed in
  task automatic send_random_request();
    int pick;
    logic [2:0] op;
    logic [7:0] v;
    logic [5:0] col;
    logic [2:0] r;
    logic [2:0] style;
    pick = $urandom_range(0, 99);
    if (pick < 6) op = OP_INIT;
    else if (pick < 12) op = OP_CLEAR;
    else if (pick < 30) op = OP_SET_POS;
    else if (pick < 40) op = OP_CURSOR;
    else if (pick < 58) op = OP_RAW_CHAR;
    else if (pick < 82) op = OP_XLAT_CHAR;
    else if (pick < 96) op = OP_RAW_CMD;
    else op = OP_UNUSED_SEVEN;
    v = 8'($urandom_range(0, 255));
    // lean translated chars toward the yo letters and the cyrillic block
    if (op == OP_XLAT_CHAR) begin
      case ($urandom_range(0, 3))
        0: v = 8'hA8;
        1: v = 8'hB8;
        2: v = 8'hC0 + 8'($urandom_range(0, 63));
        default: ;
      endcase
    end
    col = 6'($urandom_range(0, 63));
    r = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
    style = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                        : 3'($urandom_range(0, 3));
    send_request(op, v, col, r, style);
  endtask

  // sender goes quiet until every owed bus item has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_bus_items.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // bus item receiver: random stalls, or a long hold-off when one is asked
  // ---------------------------------------------------------------------------

  initial begin : bus_receiver
    int holds_served;
    int held;
    holds_served = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every taken bus item against the oldest one owed
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    bus_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_bus_items.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("cycle %0d: unexpected bus item strobe=%0b rs=%0b byte=%02h wait=%0d last=%0b",
                   cycle_count, strobe_res, register_select, bus_byte, wait_after_us,
                   bus_last);
      end else begin
        want = expected_bus_items.pop_front();
        if (strobe_res !== want.strobe || register_select !== want.rs ||
            bus_byte !== want.data || wait_after_us !== want.wait_us ||
            bus_last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("cycle %0d: expected strobe=%0b rs=%0b byte=%02h wait=%0d last=%0b",
                     cycle_count, want.strobe, want.rs, want.data, want.wait_us, want.last);
            $display("cycle %0d: got      strobe=%0b rs=%0b byte=%02h wait=%0d last=%0b",
                     cycle_count, strobe_res, register_select, bus_byte, wait_after_us,
                     bus_last);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // full power-up sequence, then let it drain
  task automatic test_init_sequence();
    send_request(OP_INIT, 8'h00, 6'd0, 3'd0, 3'd0);
    drain_results();
  endtask

  // clear, every cursor style, and one style that must make nothing
  task automatic test_clear_and_cursor();
    send_request(OP_CLEAR, 8'h00, 6'd0, 3'd0, 3'd0);
    for (int s = 0; s < 4; s++) send_request(OP_CURSOR, 8'h00, 6'd0, 3'd0, 3'(s));
    send_request(OP_CURSOR, 8'h00, 6'd0, 3'd0, 3'd7);
  endtask

  // each line base, column extremes past the visible 20, and dropped rows
  task automatic test_cursor_position();
    send_request(OP_SET_POS, 8'h00, 6'd0, 3'd0, 3'd0);
    send_request(OP_SET_POS, 8'h00, 6'd39, 3'd1, 3'd0);
    send_request(OP_SET_POS, 8'h00, 6'd63, 3'd2, 3'd0);
    send_request(OP_SET_POS, 8'h00, 6'd63, 3'd3, 3'd7);
    send_request(OP_SET_POS, 8'h00, 6'd5, 3'd4, 3'd0);
    send_request(OP_SET_POS, 8'h00, 6'd5, 3'd7, 3'd0);
  endtask

  // raw and translated chars incl. zero code and yo letters, raw commands,
  // and the unused opcode
  task automatic test_character_writes();
    send_request(OP_RAW_CHAR, 8'h00, 6'd0, 3'd0, 3'd0);
    send_request(OP_RAW_CHAR, 8'hFF, 6'd0, 3'd0, 3'd0);
    send_request(OP_XLAT_CHAR, 8'hA8, 6'd0, 3'd0, 3'd0);
    send_request(OP_XLAT_CHAR, 8'hB8, 6'd0, 3'd0, 3'd0);
    send_request(OP_XLAT_CHAR, 8'hC0, 6'd0, 3'd0, 3'd0);
    send_request(OP_XLAT_CHAR, 8'hFF, 6'd0, 3'd0, 3'd0);
    send_request(OP_RAW_CMD, 8'h00, 6'd0, 3'd0, 3'd0);
    send_request(OP_RAW_CMD, 8'hFF, 6'd0, 3'd0, 3'd0);
    send_request(OP_UNUSED_SEVEN, 8'hFF, 6'd63, 3'd7, 3'd7);
    drain_results();
  endtask

  // receiver holds off while the sender pushes without gaps, so the output
  // register fills and the request side must stall
  task automatic test_backpressure();
    calm = 1'b1;
    holds_asked++;
    repeat (24) send_random_request();
    calm = 1'b0;
    drain_results();
  endtask

  // random traffic: idling, then a long calm stretch, then idling again,
  // with one full drain in between
  task automatic test_random_traffic();
    repeat (28) send_random_request();
    drain_results();
    calm = 1'b1;
    repeat (28) send_random_request();
    calm = 1'b0;
    repeat (28) send_random_request();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = '0;
    value = '0;
    column = '0;
    row = '0;
    cursor_style = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_init_sequence();
    test_clear_and_cursor();
    test_cursor_position();
    test_character_writes();
    test_backpressure();
    test_random_traffic();
    drain_results();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/clcd_pkg.sv
rtl/clcd_item_gen.sv
rtl/char_lcd_command_sequencer.sv
rtl/clcd_checker.sv
tb/sv/tb_top.sv
